/* sv/utf8_whitespace_pretokenizer_assert.svh */
// ----------------------------------------------------------------------------
// UTF-8 whitespace pre-tokenizer assertion macros
// Concurrent assertion wrappers, removed when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_WHITESPACE_PRETOKENIZER_ASSERT_SVH
`define UTF8_WHITESPACE_PRETOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
// property that must hold on every clock edge out of reset
`define UWP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define UWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UWP_ASSERT(lbl, clk, rst_n, prop, msg)
`define UWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/uwp_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 whitespace pre-tokenizer package
// Shared types, constants and UTF-8 helper functions.
// ----------------------------------------------------------------------------
package uwp_pkg;

    localparam int UWP_QUEUE_DEPTH = 4;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [4:0]  LEAD4_TAG      = 5'h1E;

    // one queue entry: the code points produced by one input transaction
    typedef struct packed {
        logic [1:0]        cp_cnt;     // 1..3
        logic [2:0][20:0]  cps;        // cps[0] emitted first
        logic              text_last;  // transaction closed the text
    } t_uwp_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_uwp_qstat;

    // sequence length from a lead byte, 0 for stray or invalid leads
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7])                      len = 3'd1;
        else if (b[7:5] == 3'b110)      len = 3'd2;
        else if (b[7:4] == 4'hE)        len = 3'd3;
        else if (b[7:3] == LEAD4_TAG)   len = 3'd4;
        else                            len = 3'd0;
        return len;
    endfunction

    // lone byte at text end: ASCII stays, anything else is replaced
    function automatic logic [20:0] single_cp(input logic [7:0] b);
        return b[7] ? CP_REPLACEMENT : {13'd0, b};
    endfunction

    function automatic logic [20:0] decode_cp(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input logic [2:0] len);
        logic [20:0] cp;
        case (len)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = {13'd0, b0};
        endcase
        return cp;
    endfunction

    function automatic logic is_white(input logic [20:0] cp);
        return cp inside {[21'h09 : 21'h0D], 21'h20, 21'h85, 21'hA0, 21'h1680, 21'h180E,
                          [21'h2000 : 21'h200A], 21'h2028, 21'h2029, 21'h202F,
                          21'h205F, 21'h3000};
    endfunction

    function automatic logic [2:0] enc_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= 21'h7F)        len = 3'd1;
        else if (cp <= 21'h7FF)  len = 3'd2;
        else if (cp <= 21'hFFFF) len = 3'd3;
        else                     len = 3'd4;
        return len;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        case (enc_len(cp))
            3'd1: b = cp[7:0];
            3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (idx)
                    2'd0:    b = {4'hE, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {LEAD4_TAG, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

/* sv/utf8_whitespace_pretokenizer.sv */
// ----------------------------------------------------------------------------
// UTF-8 whitespace pre-tokenizer
// Lenient UTF-8 decode, re-encode and whitespace token start marking.
// ----------------------------------------------------------------------------
// Each accepted record is queued; its bytes then leave through the output register.
// Throughput: one input byte per cycle while the record queue has room; the back end
//   sends one byte per cycle while i_ready is high, so bytes that expand (a replacement
//   code point gives three) fill the QUEUE_DEPTH-entry queue and then stall the input.
// Reset: synchronous active low; clears sequence buffer counts, token tracking,
//   queue pointers and the output valid. No clearing pass.
`include "utf8_whitespace_pretokenizer_assert.svh"

module utf8_whitespace_pretokenizer #(
    parameter int QUEUE_DEPTH = uwp_pkg::UWP_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_token_start,
    output logic       o_run_last,
    output logic       o_text_end
);
    import uwp_pkg::*;

    // front -> queue
    logic        push;
    t_uwp_rec    push_rec;
    // queue -> back
    t_uwp_rec    head_rec;
    t_uwp_qstat  qstat;
    logic        pop;

    // Front end: holds the partial sequence (up to three bytes), emits a record of
    // one to three code points per transaction that finishes something. A truncated
    // sequence at text end is re-parsed here, so the back end never sees raw bytes.
    uwp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_rec     (push_rec)
    );

    // Decoupling queue: lets the input keep streaming while the back end expands
    // code points into one to four bytes each.
    uwp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_head  (head_rec),
        .o_qstat (qstat)
    );

    // Back end: walks code points and bytes of the head record, tracks whether the
    // last emitted code point was a word, and drives the output register.
    uwp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_rec),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_token_start (o_token_start),
        .o_run_last    (o_run_last),
        .o_text_end    (o_text_end)
    );

    // text end is always the last byte of its transaction
    `UWP_ASSERT(a_end_is_run_last, i_clk, i_rst_n, !(o_valid && o_text_end) || o_run_last, "text_end without run_last")
    // a token never opens on a continuation byte
    `UWP_ASSERT(a_start_on_lead, i_clk, i_rst_n, !(o_valid && o_token_start) || (o_out_byte[7:6] != 2'b10), "token start on continuation byte")
    // after a finished text, the next text's first byte must open a token
    `UWP_ASSERT_NEXT(a_restart, i_clk, i_rst_n, o_valid && i_ready && o_text_end, !o_valid || o_token_start, "no token start after text end")

endmodule

/* sv/uwp_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 whitespace pre-tokenizer front end
// Gathers multi-byte sequences and turns each transaction into code points.
// ----------------------------------------------------------------------------
module uwp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    input  uwp_pkg::t_uwp_qstat  i_qstat,
    output logic                 o_push,
    output uwp_pkg::t_uwp_rec    o_rec
);
    import uwp_pkg::*;

    logic [7:0] r_pend [3];
    logic [1:0] r_pcnt;
    logic [2:0] r_need;

    logic [1:0] n_pcnt;
    logic [2:0] n_need;
    logic       store;
    logic       accept;
    logic [7:0] b [4];
    logic [2:0] lead_len;
    logic [2:0] n_total;
    t_uwp_rec   rec;
    logic       push;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        b[0] = r_pend[0];
        b[1] = r_pend[1];
        b[2] = r_pend[2];
        b[3] = 8'h00;
        b[r_pcnt] = i_in_byte;
        lead_len  = seq_len(i_in_byte);
        n_total   = {1'b0, r_pcnt} + 3'd1;

        rec           = '0;
        rec.text_last = i_in_last;
        push          = 1'b0;
        store         = 1'b0;
        n_pcnt        = r_pcnt;
        n_need        = r_need;

        if (r_pcnt == 2'd0) begin
            if (lead_len == 3'd1) begin
                push        = 1'b1;
                rec.cp_cnt  = 2'd1;
                rec.cps[0]  = {13'd0, i_in_byte};
            end else if (lead_len == 3'd0 || i_in_last) begin
                push        = 1'b1;
                rec.cp_cnt  = 2'd1;
                rec.cps[0]  = CP_REPLACEMENT;
            end else begin
                store  = 1'b1;
                n_pcnt = 2'd1;
                n_need = lead_len;
            end
        end else if (n_total == r_need) begin
            push       = 1'b1;
            rec.cp_cnt = 2'd1;
            rec.cps[0] = decode_cp(b[0], b[1], b[2], b[3], r_need);
            n_pcnt     = 2'd0;
            n_need     = 3'd0;
        end else if (!i_in_last) begin
            store  = 1'b1;
            n_pcnt = r_pcnt + 2'd1;
        end else begin
            // truncated sequence at text end: lead is replaced, rest re-parsed
            push       = 1'b1;
            rec.cps[0] = CP_REPLACEMENT;
            if (r_pcnt == 2'd1) begin
                rec.cp_cnt = 2'd2;
                rec.cps[1] = single_cp(b[1]);
            end else if (seq_len(b[1]) == 3'd2) begin
                rec.cp_cnt = 2'd2;
                rec.cps[1] = decode_cp(b[1], b[2], 8'h00, 8'h00, 3'd2);
            end else begin
                rec.cp_cnt = 2'd3;
                rec.cps[1] = single_cp(b[1]);
                rec.cps[2] = single_cp(b[2]);
            end
        end

        if (i_in_last) begin
            n_pcnt = 2'd0;
            n_need = 3'd0;
        end
    end

    assign o_push = accept && push;
    assign o_rec  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
            r_need <= 3'd0;
        end else if (accept) begin
            r_pcnt <= n_pcnt;
            r_need <= n_need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_pend[r_pcnt] <= i_in_byte;
        end
    end

endmodule

/* sv/uwp_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 whitespace pre-tokenizer decoupling queue
// Small register FIFO of code point records between front and back end.
// ----------------------------------------------------------------------------
`include "utf8_whitespace_pretokenizer_assert.svh"

module uwp_queue #(
    parameter int DEPTH = uwp_pkg::UWP_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  uwp_pkg::t_uwp_rec    i_rec,
    input  logic                 i_pop,
    output uwp_pkg::t_uwp_rec    o_head,
    output uwp_pkg::t_uwp_qstat  o_qstat
);
    import uwp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_uwp_rec        r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop)      r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_rec;
    end

    `UWP_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_qstat.full), "push into full queue")
    `UWP_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_qstat.empty), "pop from empty queue")

endmodule

/* sv/uwp_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 whitespace pre-tokenizer back end
// Re-encodes queued code points byte by byte and marks token starts.
// ----------------------------------------------------------------------------
module uwp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  uwp_pkg::t_uwp_rec    i_head,
    input  uwp_pkg::t_uwp_qstat  i_qstat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_token_start,
    output logic                 o_run_last,
    output logic                 o_text_end
);
    import uwp_pkg::*;

    logic [1:0]  r_cp_idx;
    logic [1:0]  r_byte_idx;
    logic        r_prev_word;
    logic        r_started;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_start;
    logic        r_run_last;
    logic        r_text_end;

    logic [20:0] cp;
    logic [2:0]  len;
    logic        ws;
    logic        first;
    logic        cp_done;
    logic        rec_done;
    logic        step;

    assign cp       = i_head.cps[r_cp_idx];
    assign len      = enc_len(cp);
    assign ws       = is_white(cp);
    assign first    = (r_byte_idx == 2'd0);
    assign cp_done  = ({1'b0, r_byte_idx} == len - 3'd1);
    assign rec_done = cp_done && (r_cp_idx == i_head.cp_cnt - 2'd1);
    assign step     = !i_qstat.empty && (!r_valid || i_ready);
    assign o_pop    = step && rec_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_idx    <= 2'd0;
            r_byte_idx  <= 2'd0;
            r_prev_word <= 1'b0;
            r_started   <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (step) begin
                r_valid <= 1'b1;
                if (rec_done && i_head.text_last) begin
                    // text closed: next byte opens a fresh text
                    r_started   <= 1'b0;
                    r_prev_word <= 1'b0;
                end else if (first) begin
                    r_started   <= 1'b1;
                    r_prev_word <= !ws;
                end
                if (!cp_done) begin
                    r_byte_idx <= r_byte_idx + 2'd1;
                end else begin
                    r_byte_idx <= 2'd0;
                    r_cp_idx   <= rec_done ? 2'd0 : r_cp_idx + 2'd1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte     <= enc_byte(cp, r_byte_idx);
            r_start    <= first && (!r_started || (ws && r_prev_word));
            r_run_last <= rec_done;
            r_text_end <= rec_done && i_head.text_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_token_start = r_start;
    assign o_run_last    = r_run_last;
    assign o_text_end    = r_text_end;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// UTF-8 whitespace pre-tokenizer testbench
// Drives byte texts through the block with random stalls on both channels.
// A scoreboard predicts the re-encoded bytes and their token flags and
// compares every output transaction against them in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 190;     // random input bytes to send
    localparam int QUIET_TAIL   = 40;      // last random bytes sent with no idling
    localparam int DRAIN_CYCLES = 20;      // settle time after the last result
    localparam int LIMIT_CYCLES = 300000;  // hard stop for a hung run

    localparam logic [20:0] CP_FFFD = 21'h00FFFD;

    // one output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       tok;
        logic       run_end;
        logic       txt_end;
    } out_rec_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_token_start;
    logic       o_run_last;
    logic       o_text_end;

    utf8_whitespace_pretokenizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_token_start(o_token_start),
        .o_run_last   (o_run_last),
        .o_text_end   (o_text_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scoreboard state: a shadow copy of the decoder state and the queue
    // of output bytes still owed by the block.
    // ------------------------------------------------------------------
    out_rec_t    expected_bytes[$];
    out_rec_t    step_bytes[$];     // bytes caused by the transaction being predicted
    logic [7:0]  held_bytes[3];     // unfinished sequence, lead first
    int          held_cnt = 0;
    int          seq_need = 0;      // length of the held sequence, 0 when empty
    bit          last_was_word = 1'b0;
    bit          text_open = 1'b0;

    logic [7:0]  text_q[$];         // bytes of the text about to be sent
    bit          idle_on = 1'b0;
    int          sent_cnt = 0;
    int          texts_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          stall_left = 0;

    // length of the sequence a lead byte opens, 0 for stray or invalid leads
    function automatic int lead_len(input logic [7:0] b);
        if (!b[7])                  return 1;
        if (b[7:5] == 3'b110)       return 2;
        if (b[7:4] == 4'b1110)      return 3;
        if (b[7:3] == 5'b11110)     return 4;
        return 0;
    endfunction

    function automatic bit blank_cp(input logic [20:0] cp);
        return (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'h85 ||
               cp == 21'hA0 || cp == 21'h1680 || cp == 21'h180E ||
               (cp >= 21'h2000 && cp <= 21'h200A) || cp == 21'h2028 ||
               cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F || cp == 21'h3000;
    endfunction

    function automatic int utf8_len(input logic [20:0] cp);
        if (cp <= 21'h7F)   return 1;
        if (cp <= 21'h7FF)  return 2;
        if (cp <= 21'hFFFF) return 3;
        return 4;
    endfunction

    // byte idx of the UTF-8 form of cp; oversized values keep a lead up to 0xF7
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input int idx);
        int n;
        logic [20:0] part;
        n = utf8_len(cp);
        part = cp >> (6 * (n - 1 - idx));
        if (idx != 0) return {2'b10, part[5:0]};
        case (n)
            1:       return {1'b0, part[6:0]};
            2:       return {3'b110, part[4:0]};
            3:       return {4'b1110, part[3:0]};
            default: return {5'b11110, part[2:0]};
        endcase
    endfunction

    // a code point comes out as its UTF-8 bytes; token start on the first byte only
    function automatic void emit_code_point(input logic [20:0] cp);
        bit sp;
        bit st;
        out_rec_t r;
        sp = blank_cp(cp);
        st = !text_open || (sp && last_was_word);
        text_open = 1'b1;
        last_was_word = !sp;
        for (int idx = 0; idx < utf8_len(cp); idx++) begin
            r.data    = utf8_byte(cp, idx);
            r.tok     = (idx == 0) ? st : 1'b0;
            r.run_end = 1'b0;
            r.txt_end = 1'b0;
            step_bytes.insert(step_bytes.size(), r);
        end
    endfunction

    // Work out the bytes one accepted input transaction causes and queue them.
    function automatic void predict_byte(input logic [7:0] b, input bit last);
        logic [7:0]  seq[4];
        logic [20:0] cp;
        int n;
        int i;
        int len;
        int j;
        n = 0;
        i = 0;
        for (j = 0; j < held_cnt; j++) begin
            seq[n] = held_bytes[j];
            n++;
        end
        seq[n] = b;
        n++;
        held_cnt = 0;
        step_bytes.delete();
        while (i < n) begin
            // the head of a held sequence keeps its length even if re-read
            len = (i == 0 && seq_need != 0) ? seq_need : lead_len(seq[i]);
            if (len == 0) begin
                emit_code_point(CP_FFFD);
                i++;
            end else if (i + len <= n) begin
                case (len)
                    1:       cp = {13'd0, seq[i]};
                    2:       cp = {10'd0, seq[i][4:0], seq[i+1][5:0]};
                    3:       cp = {5'd0, seq[i][3:0], seq[i+1][5:0], seq[i+2][5:0]};
                    default: cp = {seq[i][2:0], seq[i+1][5:0], seq[i+2][5:0], seq[i+3][5:0]};
                endcase
                emit_code_point(cp);
                i += len;
            end else if (!last) begin
                // sequence not complete yet: hold it, no output
                for (j = 0; i + j < n && j < 3; j++) held_bytes[j] = seq[i + j];
                held_cnt = j;
                seq_need = len;
                break;
            end else begin
                // text ends inside a sequence: the lead alone becomes U+FFFD
                emit_code_point(CP_FFFD);
                i++;
            end
            seq_need = 0;
        end
        if (held_cnt == 0) seq_need = 0;
        if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size() - 1].run_end = 1'b1;
            if (last) step_bytes[step_bytes.size() - 1].txt_end = 1'b1;
        end
        foreach (step_bytes[k]) expected_bytes.insert(expected_bytes.size(), step_bytes[k]);
        if (last) begin
            // every text starts from a clean state
            held_cnt = 0;
            seq_need = 0;
            last_was_word = 1'b0;
            text_open = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transaction, with an optional idle burst before it.
    // valid is only ever assigned once per clock step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_byte(b, last);
        sent_cnt++;
    endtask

    // sends text_q as one text, final byte flagged
    task automatic send_text();
        for (int k = 0; k < text_q.size(); k++)
            send_byte(text_q[k], k == text_q.size() - 1);
        text_q.delete();
        texts_sent++;
    endtask

    function automatic void append_cp(input logic [20:0] cp);
        for (int idx = 0; idx < utf8_len(cp); idx++)
            text_q.insert(text_q.size(), utf8_byte(cp, idx));
    endfunction

    // one of the Unicode whitespace code points
    function automatic logic [20:0] pick_space();
        case ($urandom_range(0, 8))
            0:       return 21'($urandom_range(9, 13));
            1:       return 21'h20;
            2:       return 21'h85;
            3:       return 21'hA0;
            4:       return 21'h1680;
            5:       return 21'h180E;
            6:       return 21'($urandom_range(32'h2000, 32'h200A));
            7:       return ($urandom_range(0, 2) == 0) ? 21'h2028 :
                            ($urandom_range(0, 1) == 0) ? 21'h2029 : 21'h202F;
            default: return ($urandom_range(0, 1) == 0) ? 21'h205F : 21'h3000;
        endcase
    endfunction

    // lead byte of a 2..4 byte sequence with random payload bits
    function automatic logic [7:0] random_lead(input int n);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        case (n)
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall bursts on i_ready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // every output transaction must match the oldest owed byte
    always @(posedge i_clk) begin : check_out
        out_rec_t got;
        out_rec_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_out_byte, o_token_start, o_run_last, o_text_end};
            results_seen++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: byte=%h tok=%b run_last=%b text_end=%b",
                             got.data, got.tok, got.run_end, got.txt_end);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at output %0d: byte exp=%h got=%h tok exp=%b got=%b",
                                 results_seen, want.data, got.data, want.tok, got.tok);
                        $display("  run_last exp=%b got=%b, text_end exp=%b got=%b",
                                 want.run_end, got.run_end, want.txt_end, got.txt_end);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d bytes still owed",
                     cycles, expected_bytes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // ASCII extremes; a space after a word opens a token, the next space joins it
    task automatic test_ascii_space();
        text_q = '{8'h00, 8'h20, 8'h0D, 8'h7F};
        send_text();
    endtask

    // U+0085 leads the text, U+3000 follows whitespace (no start),
    // U+2028 follows a word (start)
    task automatic test_unicode_space();
        text_q = '{8'hC2, 8'h85, 8'hE3, 8'h80, 8'h80, 8'h41, 8'hE2, 8'h80, 8'hA8};
        send_text();
    endtask

    // stray continuation and an invalid lead each give U+FFFD
    task automatic test_bad_leads();
        text_q = '{8'h80, 8'hFF};
        send_text();
    endtask

    // text ends inside a 3-byte sequence: the lead becomes U+FFFD, the next byte is re-parsed
    task automatic test_truncated_end();
        text_q = '{8'hE1, 8'h80};
        send_text();
    endtask

    // 0x1FFFFF through a 4-byte lead, a surrogate, and an ASCII byte taken
    // as a continuation on the final transaction
    task automatic test_oversized_loose();
        text_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hC3, 8'h41};
        send_text();
    endtask

    // ------------------------------------------------------------------
    // Random texts: mostly well-formed code points, with malformed bytes,
    // loose continuations and truncated endings mixed in.
    // ------------------------------------------------------------------
    task automatic test_random_texts();
        int start_cnt;
        int ncp;
        int kind;
        int n;
        start_cnt = sent_cnt;
        while (sent_cnt - start_cnt < RANDOM_ITEMS) begin
            if (sent_cnt - start_cnt >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            ncp = $urandom_range(1, 10);
            for (int k = 0; k < ncp; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 28) begin
                    append_cp(21'($urandom_range(0, 127)));
                end else if (kind < 44) begin
                    append_cp(pick_space());
                end else if (kind < 48) begin
                    // one off a whitespace value
                    append_cp(($urandom_range(0, 1) == 0) ? pick_space() + 21'd1
                                                          : pick_space() - 21'd1);
                end else if (kind < 60) begin
                    append_cp(21'($urandom_range(32'h80, 32'h7FF)));
                end else if (kind < 70) begin
                    append_cp(21'($urandom_range(32'h800, 32'hFFFF)));
                end else if (kind < 74) begin
                    append_cp(21'($urandom_range(32'hD800, 32'hDFFF)));
                end else if (kind < 82) begin
                    append_cp(21'($urandom_range(32'h10000, 32'h1FFFFF)));
                end else if (kind < 88) begin
                    // lead followed by arbitrary bytes
                    n = $urandom_range(2, 4);
                    text_q.insert(text_q.size(), random_lead(n));
                    for (int m = 1; m < n; m++)
                        text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                end else if (kind < 94) begin
                    text_q.insert(text_q.size(), ($urandom_range(0, 1) == 0) ?
                                  8'($urandom_range(8'h80, 8'hBF)) :
                                  8'($urandom_range(8'hF8, 8'hFF)));
                end else begin
                    text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                end
            end
            // sometimes the text stops partway into a sequence
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(2, 4);
                text_q.insert(text_q.size(), random_lead(n));
                repeat ($urandom_range(0, n - 2))
                    text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
            end
            send_text();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        test_ascii_space();
        test_unicode_space();
        test_bad_leads();
        test_truncated_end();
        test_oversized_loose();
        test_random_texts();

        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d texts: %0d input bytes in, %0d output bytes checked",
                 texts_sent, sent_cnt, results_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
